@@ hdl/view_slot_allocator_macros.svh @@
// Assertion macros shared by the view slot allocator RTL.
`ifndef VIEW_SLOT_ALLOCATOR_MACROS_SVH
`define VIEW_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define VSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define VSA_ASSERT_NOW(label, clk, rst, ante, cons)
`define VSA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/vsa_pkg.sv @@
// Package: sizes, register map and transaction types of the view slot allocator.
package vsa_pkg;

  localparam int SLOTS              = 16;
  localparam int SLOT_W             = $clog2(SLOTS);
  localparam int CNT_W              = $clog2(SLOTS + 1);
  localparam int ID_W               = 8;
  localparam int PAGE_SLICE_SIZE    = 4096;
  localparam int REQUEST_SLICE_SIZE = 4096;
  localparam int COUNT_SLICE_SIZE   = 64;
  localparam logic [ID_W-1:0] MAX_VIEW_ID = 8'd255;

  localparam int PAGE_OFF_W  = 16;
  localparam int LIST_OFF_W  = 16;
  localparam int COUNT_OFF_W = 10;

  // Config register map.
  localparam int ADDR_W = 3;
  localparam int CFG_W  = 5;
  localparam logic REG_MAX_VIEW_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] MAX_VIEW_COUNT_RESET = 5'd16;

  // Request kinds.
  localparam logic ACTION_ACQUIRE = 1'b0;
  localparam logic ACTION_RELEASE = 1'b1;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] view_id;
  } req_t;

  typedef struct packed {
    logic                   granted;
    logic [SLOT_W-1:0]      slot_index;
    logic [PAGE_OFF_W-1:0]  page_offset;
    logic [LIST_OFF_W-1:0]  request_list_offset;
    logic [COUNT_OFF_W-1:0] request_count_offset;
  } rsp_t;

endpackage

@@ hdl/view_slot_allocator.sv @@
// View slot allocator: slot table with view ID lookup, lowest-free reuse and append.
// Path: a transaction accepted on start passes the input register, then one lookup/update
//   pass into the result registers, where done strobes it.
// Throughput: one per cycle; busy stays low, results cannot be stalled; releases give no result.
// Reset (rst, synchronous): frees all slots, clears the used count, drops any pending
//   transaction, and sets max_view_count to 16.
`include "view_slot_allocator_macros.svh"

module view_slot_allocator (
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  vsa_pkg::req_t              req,
  output logic                       done,
  output vsa_pkg::rsp_t              result,
  // APB config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [vsa_pkg::CFG_W-1:0] max_view_count;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_view_count <= vsa_pkg::MAX_VIEW_COUNT_RESET;
    end else if (cfg_wr && (paddr[2] == vsa_pkg::REG_MAX_VIEW_COUNT)) begin
      max_view_count <= pwdata[vsa_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == vsa_pkg::REG_MAX_VIEW_COUNT) begin
      prdata = {{(32 - vsa_pkg::CFG_W){1'b0}}, max_view_count};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: every transaction is captured, the pass below sees state
  // already updated by the previous transaction.
  // ---------------------------------------------------------------------------
  logic                      in_valid;
  logic                      in_action;
  logic [vsa_pkg::ID_W-1:0]  in_id;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_action <= req.action;
      in_id     <= req.view_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot table. Owner IDs carry no reset; they are only looked at where busy.
  // ---------------------------------------------------------------------------
  logic [vsa_pkg::SLOTS-1:0]  slot_busy;
  logic [vsa_pkg::SLOTS-1:0]  slot_busy_next;
  logic [vsa_pkg::ID_W-1:0]   slot_owner [vsa_pkg::SLOTS];
  logic [vsa_pkg::CNT_W-1:0]  slots_used;
  logic [vsa_pkg::CNT_W-1:0]  slots_used_next;

  // Lookup pass
  logic                       legal;
  logic [vsa_pkg::SLOTS-1:0]  used_mask;
  logic [vsa_pkg::SLOTS-1:0]  match;
  logic [vsa_pkg::SLOTS-1:0]  free_slot;
  logic                       any_match;
  logic                       any_free;
  logic [vsa_pkg::SLOT_W-1:0] match_idx;
  logic [vsa_pkg::SLOT_W-1:0] free_idx;
  logic [vsa_pkg::CNT_W-1:0]  cap;
  logic                       can_append;

  logic                       owner_we;
  logic [vsa_pkg::SLOT_W-1:0] owner_idx;
  logic                       grant;
  logic [vsa_pkg::SLOT_W-1:0] grant_idx;
  logic                       emit;
  vsa_pkg::rsp_t              result_next;

  assign legal = (in_id != '0) && (in_id <= vsa_pkg::MAX_VIEW_ID);
  assign cap   = (max_view_count < vsa_pkg::CNT_W'(vsa_pkg::SLOTS)) ?
                 max_view_count : vsa_pkg::CNT_W'(vsa_pkg::SLOTS);
  assign can_append = slots_used < cap;

  always_comb begin
    for (int i = 0; i < vsa_pkg::SLOTS; i++) begin
      used_mask[i] = vsa_pkg::CNT_W'(i) < slots_used;
      match[i]     = slot_busy[i] && (slot_owner[i] == in_id);
      free_slot[i] = !slot_busy[i] && used_mask[i];
    end
  end

  assign any_match = |match;
  assign any_free  = |free_slot;

  // Lowest-index pick for both the ID hit and the free slot.
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = vsa_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = vsa_pkg::SLOT_W'(i);
      end
      if (free_slot[i]) begin
        free_idx = vsa_pkg::SLOT_W'(i);
      end
    end
  end

  // Table update and grant decision
  always_comb begin
    slot_busy_next  = slot_busy;
    slots_used_next = slots_used;
    owner_we        = 1'b0;
    owner_idx       = free_idx;
    grant           = 1'b0;
    grant_idx       = '0;
    emit            = 1'b0;
    if (in_valid) begin
      if (in_action == vsa_pkg::ACTION_RELEASE) begin
        if (legal && any_match) begin
          slot_busy_next[match_idx] = 1'b0;
        end
      end else begin
        emit = 1'b1;
        if (legal) begin
          priority if (any_match) begin
            grant     = 1'b1;
            grant_idx = match_idx;
          end else if (any_free) begin
            grant     = 1'b1;
            grant_idx = free_idx;
            owner_we  = 1'b1;
            owner_idx = free_idx;
            slot_busy_next[free_idx] = 1'b1;
          end else if (can_append) begin
            grant     = 1'b1;
            grant_idx = slots_used[vsa_pkg::SLOT_W-1:0];
            owner_we  = 1'b1;
            owner_idx = slots_used[vsa_pkg::SLOT_W-1:0];
            slot_busy_next[owner_idx] = 1'b1;
            slots_used_next = slots_used + vsa_pkg::CNT_W'(1);
          end else begin
            grant = 1'b0;
          end
        end
      end
    end
  end

  // Offsets are the index times fixed slice sizes, cut to the field widths.
  always_comb begin
    result_next = '0;
    if (grant) begin
      result_next.granted              = 1'b1;
      result_next.slot_index           = grant_idx;
      result_next.page_offset          = vsa_pkg::PAGE_OFF_W'(
        32'(grant_idx) * 32'(vsa_pkg::PAGE_SLICE_SIZE));
      result_next.request_list_offset  = vsa_pkg::LIST_OFF_W'(
        32'(grant_idx) * 32'(vsa_pkg::REQUEST_SLICE_SIZE));
      result_next.request_count_offset = vsa_pkg::COUNT_OFF_W'(
        32'(grant_idx) * 32'(vsa_pkg::COUNT_SLICE_SIZE));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy  <= '0;
      slots_used <= '0;
      done       <= 1'b0;
    end else begin
      slot_busy  <= slot_busy_next;
      slots_used <= slots_used_next;
      done       <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      slot_owner[owner_idx] <= in_id;
    end
    result <= result_next;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Owned slots always lie below the used count.
  `VSA_ASSERT_NOW(a_busy_below_used, clk, rst, 1'b1, (slot_busy & ~used_mask) == '0)

  // A granted slot is owned when its result is strobed.
  `VSA_ASSERT_NOW(a_grant_owned, clk, rst, done && result.granted,
                  slot_busy[result.slot_index])

  // A refused acquire carries all-zero fields.
  `VSA_ASSERT_NOW(a_refuse_zero, clk, rst, done && !result.granted,
                  result.slot_index == '0 && result.page_offset == '0 &&
                  result.request_list_offset == '0 && result.request_count_offset == '0)

  // The used count only ever steps up by one and stays within the table.
  `VSA_ASSERT_NEXT(a_used_step, clk, rst, 1'b1,
                   (slots_used == $past(slots_used) ||
                    slots_used == $past(slots_used) + vsa_pkg::CNT_W'(1)) &&
                   slots_used <= vsa_pkg::CNT_W'(vsa_pkg::SLOTS))

endmodule

@@ bench/tb_view_slot_allocator.sv @@
// Testbench for view_slot_allocator: directed table then random traffic, checked by a predictor.
`timescale 1ns / 100ps

module tb_view_slot_allocator;

  // Clocking and run control.
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  // A result is registered behind the input register before it is sampled; leave margin.
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 117;

  // Byte addresses: the capacity register, and the first address past the register list.
  localparam logic [vsa_pkg::ADDR_W-1:0] ADDR_CAP   =
    vsa_pkg::ADDR_W'(4 * vsa_pkg::REG_MAX_VIEW_COUNT);
  localparam logic [vsa_pkg::ADDR_W-1:0] ADDR_SPARE =
    vsa_pkg::ADDR_W'(4 * (vsa_pkg::REG_MAX_VIEW_COUNT + 1));

  localparam logic [vsa_pkg::ID_W-1:0] ID_NONE = '0;

  typedef enum bit { ROW_ITEM, ROW_WRITE } row_kind_e;

  // One row of the directed plan: a transaction (optionally with a typed-in
  // expectation) or a register write.
  typedef struct packed {
    row_kind_e                  kind;
    vsa_pkg::req_t              rq;
    logic [vsa_pkg::ADDR_W-1:0] addr;
    logic [vsa_pkg::CFG_W-1:0]  val;
    bit                         pinned;
    vsa_pkg::rsp_t              rsp;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  vsa_pkg::req_t req;
  logic        done;
  vsa_pkg::rsp_t result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [vsa_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  view_slot_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the slot table and capacity register.
  logic [vsa_pkg::ID_W-1:0]  owner_tab [vsa_pkg::SLOTS];
  bit                        taken_tab [vsa_pkg::SLOTS];
  int unsigned               appended;
  logic [vsa_pkg::CFG_W-1:0] cap_reg;

  // Grants still owed by the DUT, oldest first.
  vsa_pkg::rsp_t grants_due[$];
  int   fails;
  int   stall_cnt;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Build the response for a slot (or a rejection when ok is 0); offsets wrap
  // to their field widths.
  function automatic vsa_pkg::rsp_t grant_for(input bit ok, input int unsigned slot);
    vsa_pkg::rsp_t g;
    int unsigned s;
    s = ok ? slot : 0;
    g.granted              = ok;
    g.slot_index           = vsa_pkg::SLOT_W'(s);
    g.page_offset          = vsa_pkg::PAGE_OFF_W'(s * vsa_pkg::PAGE_SLICE_SIZE);
    g.request_list_offset  = vsa_pkg::LIST_OFF_W'(s * vsa_pkg::REQUEST_SLICE_SIZE);
    g.request_count_offset = vsa_pkg::COUNT_OFF_W'(s * vsa_pkg::COUNT_SLICE_SIZE);
    return g;
  endfunction

  // Apply one transaction to the shadow table. Returns 1 when the DUT owes a
  // result (acquire only), with the expected grant in g.
  function automatic bit allocate_slot(input vsa_pkg::req_t r, output vsa_pkg::rsp_t g);
    bit          legal;
    int unsigned used;
    int unsigned cap;
    g     = '0;
    legal = (r.view_id != ID_NONE) && (r.view_id <= vsa_pkg::MAX_VIEW_ID);
    used  = (appended < vsa_pkg::SLOTS) ? appended : vsa_pkg::SLOTS;

    if (r.action == vsa_pkg::ACTION_RELEASE) begin
      // Free the first slot this id holds; unknown or illegal ids are no-ops.
      if (legal) begin
        for (int i = 0; i < used; i++) begin
          if (taken_tab[i] && owner_tab[i] == r.view_id) begin
            taken_tab[i] = 1'b0;
            break;
          end
        end
      end
      return 1'b0;
    end

    if (!legal) begin
      g = grant_for(1'b0, 0);
      return 1'b1;
    end

    // Already owned: hand back the same slot.
    for (int i = 0; i < used; i++) begin
      if (taken_tab[i] && owner_tab[i] == r.view_id) begin
        g = grant_for(1'b1, i);
        return 1'b1;
      end
    end

    // Lowest freed slot below the append count.
    for (int i = 0; i < used; i++) begin
      if (!taken_tab[i]) begin
        taken_tab[i] = 1'b1;
        owner_tab[i] = r.view_id;
        g = grant_for(1'b1, i);
        return 1'b1;
      end
    end

    // Append, limited by the smaller of the register and the table size.
    cap = (cap_reg < vsa_pkg::SLOTS) ? cap_reg : vsa_pkg::SLOTS;
    if (used >= cap) begin
      g = grant_for(1'b0, 0);
      return 1'b1;
    end
    taken_tab[used] = 1'b1;
    owner_tab[used] = r.view_id;
    appended        = used + 1;
    g = grant_for(1'b1, used);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // Result monitor: every strobe must match the oldest grant owed.
  always @(posedge clk) begin
    vsa_pkg::rsp_t want;
    if (!rst && done === 1'b1) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: no transaction pending");
        fails++;
      end else begin
        want = grants_due.pop_front();
        check_field("granted", want.granted, result.granted);
        check_field("slot_index", want.slot_index, result.slot_index);
        check_field("page_offset", want.page_offset, result.page_offset);
        check_field("request_list_offset", want.request_list_offset,
                    result.request_list_offset);
        check_field("request_count_offset", want.request_count_offset,
                    result.request_count_offset);
      end
    end
  end

  // Watchdog: any accepted transaction, result or APB access counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Present one transaction from a falling edge and hold it until accepted.
  // Returns at the falling edge after acceptance with start still high.
  task automatic issue(input vsa_pkg::req_t r, input bit pinned, input vsa_pkg::rsp_t typed);
    vsa_pkg::rsp_t g;
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    if (allocate_slot(r, g)) grants_due = {grants_due, pinned ? typed : g};
    @(negedge clk);
  endtask

  // Let every owed result arrive, then let any trailing release drain out of
  // the pipeline before the register is touched.
  task automatic settle();
    start = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write (setup + access), then read back when the address is mapped.
  task automatic program_reg(input logic [vsa_pkg::ADDR_W-1:0] a,
                             input logic [vsa_pkg::CFG_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = a;
    pwdata  = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (a == ADDR_CAP) cap_reg = v;   // the only other address used lies past the map
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (a == ADDR_CAP) begin
      @(negedge clk);
      psel   = 1'b1;
      pwrite = 1'b0;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      check_field("max_view_count", 32'(cap_reg), prdata);
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  initial begin
    row_t        plan[$];
    logic [vsa_pkg::ID_W-1:0] pool[$];
    vsa_pkg::req_t r;
    int          burst_left;
    int          gap;
    int          pool_n;
    int          caps[RAND_PHASES];

    fails     = 0;
    stall_cnt = 0;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    cap_reg  = vsa_pkg::MAX_VIEW_COUNT_RESET;
    appended = 0;
    for (int i = 0; i < vsa_pkg::SLOTS; i++) begin
      taken_tab[i] = 1'b0;
      owner_tab[i] = '0;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed plan. Typed expectations: rejections, and the first grant of an
    // empty table and its repeat (slot 0, all offsets zero). The rest goes through the predictor.
    plan = '{
      // illegal id: acquire is rejected, release is ignored
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, ID_NONE}, '0, '0, 1'b1, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_RELEASE, ID_NONE}, '0, '0, 1'b0, '0},
      // zero capacity: nothing can be appended
      '{ROW_WRITE, '0, ADDR_CAP, 5'd0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd1}, '0, '0, 1'b1, '0},
      // write past the register list must not change capacity
      '{ROW_WRITE, '0, ADDR_SPARE, 5'd16, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd1}, '0, '0, 1'b1, '0},
      '{ROW_WRITE, '0, ADDR_CAP, 5'd2, 1'b0, '0},
      // max id gets slot 0, and the same slot again on a repeat acquire
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, vsa_pkg::MAX_VIEW_ID}, '0, '0, 1'b1,
        '{1'b1, '0, '0, '0, '0}},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, vsa_pkg::MAX_VIEW_ID}, '0, '0, 1'b1,
        '{1'b1, '0, '0, '0, '0}},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd1}, '0, '0, 1'b0, '0},
      // table full at capacity 2
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd2}, '0, '0, 1'b0, '0},
      // release of an id that owns nothing
      '{ROW_ITEM,  '{vsa_pkg::ACTION_RELEASE, 8'd3}, '0, '0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_RELEASE, vsa_pkg::MAX_VIEW_ID}, '0, '0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd170}, '0, '0, 1'b0, '0},
      // both slots freed: the lowest one is reused
      '{ROW_ITEM,  '{vsa_pkg::ACTION_RELEASE, 8'd1}, '0, '0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_RELEASE, 8'd170}, '0, '0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd85}, '0, '0, 1'b0, '0},
      // capacity below the count: freed slot still reusable, no append
      '{ROW_WRITE, '0, ADDR_CAP, 5'd1, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd86}, '0, '0, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd87}, '0, '0, 1'b0, '0},
      '{ROW_WRITE, '0, ADDR_CAP, 5'd16, 1'b0, '0},
      '{ROW_ITEM,  '{vsa_pkg::ACTION_ACQUIRE, 8'd128}, '0, '0, 1'b0, '0}
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        program_reg(plan[i].addr, plan[i].val);
      end else begin
        issue(plan[i].rq, plan[i].pinned, plan[i].rsp);
        // Occasionally drop start so directed rows also see idle cycles.
        if ($urandom_range(0, 1) == 0) begin
          start = 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end
      end
    end

    // Random phases. Low capacities first, since the append count never falls;
    // the full 16 comes last so the top slot and its offsets get exercised.
    caps = '{3, 0, 5, 1, 9, 16, 12, 16};
    burst_left = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      program_reg(ADDR_CAP, vsa_pkg::CFG_W'(caps[p]));

      // Small id pools force re-acquires and releases that hit; large ones
      // overflow the table.
      pool.delete();
      pool_n = $urandom_range(2, 24);
      for (int k = 0; k < pool_n; k++) begin
        pool = {pool, vsa_pkg::ID_W'($urandom_range(1, 255))};
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
          end
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;

        r.action = ($urandom_range(0, 9) < 4) ? vsa_pkg::ACTION_RELEASE
                                              : vsa_pkg::ACTION_ACQUIRE;
        case ($urandom_range(0, 15))
          0:       r.view_id = ID_NONE;
          1:       r.view_id = vsa_pkg::ID_W'($urandom_range(1, 255));
          default: r.view_id = pool[$urandom_range(0, pool_n - 1)];
        endcase
        issue(r, 1'b0, '0);
      end
    end

    // Drain: all owed results, then a few more cycles to catch strays.
    start = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/vsa_pkg.sv
hdl/view_slot_allocator.sv
bench/tb_view_slot_allocator.sv
